// ----- rtl/pcfv_pkg.sv -----
// shared types and constants for the point charge field vector block
package pcfv_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_GAIN    = 1'b0,
        CFG_MIN_DIST = 1'b1
    } cfg_index_t;

    localparam logic [31:0] GAIN_RESET     = 32'd589;
    localparam logic [15:0] MIN_DIST_RESET = 16'd15;

    localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

// ----- rtl/pcfv_sqrt_cell.sv -----
// one bit of the restoring square root, one cell per result bit
module pcfv_sqrt_cell #(
    parameter int VW     = 67,
    parameter int SW     = 34,
    parameter int BIT    = 0,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vin,
    input  logic [VW-1:0]     rem_in,
    input  logic [SW-1:0]     root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vout,
    output logic [VW-1:0]     rem_out,
    output logic [SW-1:0]     root_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam logic [VW:0] ONE_W  = (VW+1)'(1);
    localparam logic [SW-1:0] ONE_S = SW'(1);

    logic [VW:0]       trial;
    logic              take;
    logic [VW-1:0]     rem_next;
    logic [SW-1:0]     root_next;
    logic              vld_reg;
    logic [VW-1:0]     rem_reg;
    logic [SW-1:0]     root_reg;
    logic [SIDE_W-1:0] side_reg;

    // trial subtrahend (2r + 2^b) * 2^b
    always_comb
    begin
        trial     = ((VW+1)'(root_in) << (BIT + 1)) + (ONE_W << (2 * BIT));
        take      = ({1'b0, rem_in} >= trial);
        rem_next  = take ? VW'({1'b0, rem_in} - trial) : rem_in;
        root_next = take ? (root_in | (ONE_S << BIT)) : root_in;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vin;
    end

    // data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vout     = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/pcfv_div_cell.sv -----
// one quotient bit of both field components, restoring division
module pcfv_div_cell #(
    parameter int DENW   = 69,
    parameter int NW     = 81,
    parameter int SIDE_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vin,
    input  logic [DENW-1:0]   den_in,
    input  logic [NW-1:0]     numx_in,
    input  logic [NW-1:0]     numy_in,
    input  logic [DENW-1:0]   remx_in,
    input  logic [DENW-1:0]   remy_in,
    input  logic [NW-1:0]     qx_in,
    input  logic [NW-1:0]     qy_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vout,
    output logic [DENW-1:0]   den_out,
    output logic [NW-1:0]     numx_out,
    output logic [NW-1:0]     numy_out,
    output logic [DENW-1:0]   remx_out,
    output logic [DENW-1:0]   remy_out,
    output logic [NW-1:0]     qx_out,
    output logic [NW-1:0]     qy_out,
    output logic [SIDE_W-1:0] side_out
);

    logic [DENW:0]     shx;
    logic [DENW:0]     shy;
    logic              bx;
    logic              by;
    logic              vld_reg;
    logic [DENW-1:0]   den_reg;
    logic [NW-1:0]     numx_reg;
    logic [NW-1:0]     numy_reg;
    logic [DENW-1:0]   remx_reg;
    logic [DENW-1:0]   remy_reg;
    logic [NW-1:0]     qx_reg;
    logic [NW-1:0]     qy_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DENW-1:0]   remx_next;
    logic [DENW-1:0]   remy_next;

    // shift in next numerator bit, compare and subtract
    always_comb
    begin
        shx       = {remx_in, numx_in[NW-1]};
        shy       = {remy_in, numy_in[NW-1]};
        bx        = (shx >= {1'b0, den_in});
        by        = (shy >= {1'b0, den_in});
        remx_next = bx ? DENW'(shx - {1'b0, den_in}) : DENW'(shx);
        remy_next = by ? DENW'(shy - {1'b0, den_in}) : DENW'(shy);
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vin;
    end

    // data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            numx_reg <= {numx_in[NW-2:0], 1'b0};
            numy_reg <= {numy_in[NW-2:0], 1'b0};
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            qx_reg   <= {qx_in[NW-2:0], bx};
            qy_reg   <= {qy_in[NW-2:0], by};
            side_reg <= side_in;
        end
    end

    assign vout     = vld_reg;
    assign den_out  = den_reg;
    assign numx_out = numx_reg;
    assign numy_out = numy_reg;
    assign remx_out = remx_reg;
    assign remy_out = remy_reg;
    assign qx_out   = qx_reg;
    assign qy_out   = qy_reg;
    assign side_out = side_reg;

endmodule

// ----- rtl/point_charge_field_vector.sv -----
// top level: 2-d field of one point charge at one probe point
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    charge_x, charge_y, charge_amount, point_x, point_y
//  m_axis   out  m_axis_tvalid/tready    field_x, field_y; tuser too_close
//  cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one item per cycle unless the output stalls; an item passes stages 1 and 2, the square
// root cells (one per root bit), stages 3 and 4, the divider cells (one per quotient bit)
// and the output register; reset clears all valid flags and loads the register defaults
// a stalled output freezes the whole row of cells; cfg_ready is always high
module point_charge_field_vector #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // charge_x, charge_y, charge_amount, point_x, point_y, zero fill
    input  logic [((4*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // field_x, field_y
    output logic [63:0]           m_axis_tdata,
    // too_close
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int MW   = CB + 1;
    localparam int D2W  = 2 * MW + 1;
    localparam int VW   = D2W + 32;
    localparam int SW   = (VW + 1) / 2;
    localparam int SL   = SW / 2;
    localparam int SH   = SW - SL;
    localparam int DENW = D2W + SW;
    localparam int NW   = 64 + MW;
    localparam int SQS  = D2W + 2 * MW + 64 + 3;

    logic en;
    logic [31:0] gain_reg;
    logic [15:0] mind_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= pcfv_pkg::GAIN_RESET;
            mind_reg <= pcfv_pkg::MIN_DIST_RESET;
        end
        else if (cfg_valid)
        begin
            case (pcfv_pkg::cfg_index_t'(cfg_index))
                pcfv_pkg::CFG_GAIN:     gain_reg <= cfg_data;
                pcfv_pkg::CFG_MIN_DIST: mind_reg <= cfg_data[15:0];
                default:                gain_reg <= gain_reg;
            endcase
        end
    end

    // whole row moves unless a result waits
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: deltas, magnitudes, gain times charge, minimum distance squared
    logic signed [MW-1:0] dx, dy;
    logic [CB-1:0] cx, cy, px, py;
    logic [31:0] q;
    assign cx = s_axis_tdata[CB-1:0];
    assign cy = s_axis_tdata[2*CB-1:CB];
    assign q  = s_axis_tdata[2*CB+31:2*CB];
    assign px = s_axis_tdata[3*CB+31:2*CB+32];
    assign py = s_axis_tdata[4*CB+31:3*CB+32];
    assign dx = $signed({px[CB-1], px}) - $signed({cx[CB-1], cx});
    assign dy = $signed({py[CB-1], py}) - $signed({cy[CB-1], cy});

    logic          v1_reg;
    logic [MW-1:0] mx1_reg, my1_reg;
    logic          nx1_reg, ny1_reg, qn1_reg;
    logic [63:0]   gq1_reg;
    logic [31:0]   md1_reg;
    logic [31:0]   qmag;
    assign qmag = q[31] ? (32'd0 - q) : q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx1_reg <= dx[MW-1] ? MW'(-dx) : MW'(dx);
            my1_reg <= dy[MW-1] ? MW'(-dy) : MW'(dy);
            nx1_reg <= dx[MW-1];
            ny1_reg <= dy[MW-1];
            qn1_reg <= q[31];
            gq1_reg <= 64'(gain_reg) * 64'(qmag);
            md1_reg <= 32'(mind_reg) * 32'(mind_reg);
        end
    end

    // stage 2: squared distance and too close test
    logic            v2_reg;
    logic [D2W-1:0]  d2_next, d2_reg;
    logic [MW-1:0]   mx2_reg, my2_reg;
    logic [63:0]     gq2_reg;
    logic            negx2_reg, negy2_reg, close2_reg;
    assign d2_next = D2W'(D2W'(mx1_reg) * D2W'(mx1_reg)) + D2W'(D2W'(my1_reg) * D2W'(my1_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg     <= d2_next;
            mx2_reg    <= mx1_reg;
            my2_reg    <= my1_reg;
            gq2_reg    <= gq1_reg;
            negx2_reg  <= qn1_reg ^ nx1_reg;
            negy2_reg  <= qn1_reg ^ ny1_reg;
            close2_reg <= (d2_next == '0) ||
                          ((D2W > 32 ? D2W : 32)'(d2_next) < (D2W > 32 ? D2W : 32)'(md1_reg));
        end
    end

    // square root row: root of d2 * 2^32
    logic           sq_v    [0:SW];
    logic [VW-1:0]  sq_rem  [0:SW];
    logic [SW-1:0]  sq_root [0:SW];
    logic [SQS-1:0] sq_side [0:SW];
    assign sq_v[0]    = v2_reg;
    assign sq_rem[0]  = {d2_reg, 32'd0};
    assign sq_root[0] = '0;
    assign sq_side[0] = {d2_reg, mx2_reg, my2_reg, gq2_reg, negx2_reg, negy2_reg, close2_reg};

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        pcfv_sqrt_cell #(.VW(VW), .SW(SW), .BIT(SW - 1 - k), .SIDE_W(SQS)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(sq_v[k]), .rem_in(sq_rem[k]), .root_in(sq_root[k]), .side_in(sq_side[k]),
            .vout(sq_v[k+1]), .rem_out(sq_rem[k+1]), .root_out(sq_root[k+1]),
            .side_out(sq_side[k+1])
        );
    end

    // stage 3: partial products of denominator and numerators
    logic [D2W-1:0] d2s;
    logic [MW-1:0]  mxs, mys;
    logic [63:0]    gqs;
    logic           negxs, negys, closes;
    logic [SW-1:0]  root;
    assign {d2s, mxs, mys, gqs, negxs, negys, closes} = sq_side[SW];
    assign root = sq_root[SW];

    logic              v3_reg;
    logic [D2W+SL-1:0] pdl_reg;
    logic [D2W+SH-1:0] pdh_reg;
    logic [31+MW:0]    pxl_reg, pxh_reg, pyl_reg, pyh_reg;
    logic              negx3_reg, negy3_reg, close3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= sq_v[SW];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pdl_reg    <= (D2W+SL)'(d2s) * (D2W+SL)'(root[SL-1:0]);
            pdh_reg    <= (D2W+SH)'(d2s) * (D2W+SH)'(root[SW-1:SL]);
            pxl_reg    <= (32+MW)'(gqs[31:0]) * (32+MW)'(mxs);
            pxh_reg    <= (32+MW)'(gqs[63:32]) * (32+MW)'(mxs);
            pyl_reg    <= (32+MW)'(gqs[31:0]) * (32+MW)'(mys);
            pyh_reg    <= (32+MW)'(gqs[63:32]) * (32+MW)'(mys);
            negx3_reg  <= negxs;
            negy3_reg  <= negys;
            close3_reg <= closes;
        end
    end

    // stage 4: sum the partial products
    logic            v4_reg;
    logic [DENW-1:0] den4_reg;
    logic [NW-1:0]   nx4_reg, ny4_reg;
    logic [2:0]      side4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den4_reg  <= DENW'(pdl_reg) + (DENW'(pdh_reg) << SL);
            nx4_reg   <= NW'(pxl_reg) + (NW'(pxh_reg) << 32);
            ny4_reg   <= NW'(pyl_reg) + (NW'(pyh_reg) << 32);
            side4_reg <= {negx3_reg, negy3_reg, close3_reg};
        end
    end

    // divider row: one quotient bit per cell
    logic            dv_v    [0:NW];
    logic [DENW-1:0] dv_den  [0:NW];
    logic [NW-1:0]   dv_nx   [0:NW];
    logic [NW-1:0]   dv_ny   [0:NW];
    logic [DENW-1:0] dv_rx   [0:NW];
    logic [DENW-1:0] dv_ry   [0:NW];
    logic [NW-1:0]   dv_qx   [0:NW];
    logic [NW-1:0]   dv_qy   [0:NW];
    logic [2:0]      dv_side [0:NW];
    assign dv_v[0]    = v4_reg;
    assign dv_den[0]  = den4_reg;
    assign dv_nx[0]   = nx4_reg;
    assign dv_ny[0]   = ny4_reg;
    assign dv_rx[0]   = '0;
    assign dv_ry[0]   = '0;
    assign dv_qx[0]   = '0;
    assign dv_qy[0]   = '0;
    assign dv_side[0] = side4_reg;

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        pcfv_div_cell #(.DENW(DENW), .NW(NW), .SIDE_W(3)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .vin(dv_v[k]),
            .den_in(dv_den[k]), .numx_in(dv_nx[k]), .numy_in(dv_ny[k]),
            .remx_in(dv_rx[k]), .remy_in(dv_ry[k]), .qx_in(dv_qx[k]), .qy_in(dv_qy[k]),
            .side_in(dv_side[k]), .vout(dv_v[k+1]),
            .den_out(dv_den[k+1]), .numx_out(dv_nx[k+1]), .numy_out(dv_ny[k+1]),
            .remx_out(dv_rx[k+1]), .remy_out(dv_ry[k+1]),
            .qx_out(dv_qx[k+1]), .qy_out(dv_qy[k+1]), .side_out(dv_side[k+1])
        );
    end

    // sign, saturation and too close forcing
    function automatic logic [31:0] pcfv_sat(input logic [NW-1:0] mag, input logic neg);
        logic big_pos;
        logic big_neg;
        begin
            big_pos = (mag > NW'(pcfv_pkg::SAT_POS));
            big_neg = (mag >= NW'(pcfv_pkg::SAT_NEG));
            if (!neg)
                pcfv_sat = big_pos ? pcfv_pkg::SAT_POS : mag[31:0];
            else
                pcfv_sat = big_neg ? pcfv_pkg::SAT_NEG : (32'd0 - mag[31:0]);
        end
    endfunction

    logic        out_v_reg;
    logic [63:0] out_d_reg;
    logic        out_u_reg;
    logic        fin_close;
    assign fin_close = dv_side[NW][0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_v[NW];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg <= fin_close ? 64'd0 :
                         {pcfv_sat(dv_qy[NW], dv_side[NW][1]),
                          pcfv_sat(dv_qx[NW], dv_side[NW][2])};
            out_u_reg <= fin_close;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;
    assign m_axis_tuser  = out_u_reg;

    // a flagged result carries zero components
    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("too close result with nonzero field");

    // a minimum distance write lands in the register
    a_cfg_mind: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == pcfv_pkg::CFG_MIN_DIST
        |=> mind_reg == $past(cfg_data[15:0]))
        else $error("minimum distance write lost");

    // the row holds still while a result waits
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(dv_v[NW]) && $stable(sq_v[SW]))
        else $error("cell row moved during stall");

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the point charge field vector block: table-driven and random stream checks
`timescale 1ns / 100ps

module tb_top;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        tc;
    } field_t;

    typedef struct {
        int          phase;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [31:0] q;
        logic [15:0] px;
        logic [15:0] py;
        bit          fixed;
        field_t      res;
    } vec_row_t;

    // model copy of the registers
    logic [31:0] gain_q16;
    logic [15:0] min_dist;

    field_t expected_fields[$];
    int     errors;
    int     tx_idle_pct;
    int     rx_idle_pct;
    bit     rx_hold_req;

    point_charge_field_vector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    // one field component: scale, divide, sign and saturate
    function automatic logic [31:0] field_component(input logic [63:0] gq, input bit q_neg,
                                                    input logic signed [17:0] delta,
                                                    input logic [127:0] den);
        logic [127:0] quot;
        logic [17:0]  dmag;
        bit           neg;
        dmag = delta < 0 ? -delta : delta;
        quot = ({64'd0, gq} * {110'd0, dmag}) / den;
        neg  = q_neg != (delta < 0);
        if (!neg)
            return (quot > 128'h7fff_ffff) ? pcfv_pkg::SAT_POS : quot[31:0];
        if (quot >= 128'h8000_0000)
            return pcfv_pkg::SAT_NEG;
        return -quot[31:0];
    endfunction

    // expected field of one charge at one probe point
    function automatic field_t coulomb_field(input logic [15:0] cx, input logic [15:0] cy,
                                             input logic [31:0] q, input logic [15:0] px,
                                             input logic [15:0] py);
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic [17:0]        mx;
        logic [17:0]        my;
        logic [63:0]        d2;
        logic [127:0]       shifted;
        logic [127:0]       root;
        logic [127:0]       trial;
        logic [63:0]        qmag;
        logic [63:0]        gq;
        field_t             r;
        dx = $signed(px) - $signed(cx);
        dy = $signed(py) - $signed(cy);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        d2 = mx * mx + my * my;
        r  = '0;
        if (d2 == 0 || d2 < {32'd0, min_dist} * {32'd0, min_dist})
        begin
            r.tc = 1'b1;
            return r;
        end
        shifted = {64'd0, d2} << 32;
        root = 0;
        for (int b = 47; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= shifted)
                root = trial;
        end
        qmag = $signed(q) < 0 ? {32'd0, -q} : {32'd0, q};
        gq   = {32'd0, gain_q16} * qmag;
        r.fx = field_component(gq, q[31], dx, {64'd0, d2} * root);
        r.fy = field_component(gq, q[31], dy, {64'd0, d2} * root);
        return r;
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        int hold_cnt;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt = 0;
        end
        else if (rx_hold_req && hold_cnt < 400)
        begin
            hold_cnt++;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!rx_hold_req)
                hold_cnt = 0;
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        field_t exp_f;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_fields.size() == 0)
            begin
                $error("unexpected result transfer: tdata=%h tuser=%b", m_axis_tdata,
                       m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_f = expected_fields.pop_front();
                if (m_axis_tdata[31:0] !== exp_f.fx)
                begin
                    $error("field_x: expected %0d, got %0d", $signed(exp_f.fx),
                           $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[63:32] !== exp_f.fy)
                begin
                    $error("field_y: expected %0d, got %0d", $signed(exp_f.fy),
                           $signed(m_axis_tdata[63:32]));
                    errors++;
                end
                if (m_axis_tuser !== exp_f.tc)
                begin
                    $error("too_close: expected %0b, got %0b", exp_f.tc, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // register write, only while idle
    task automatic write_reg(input pcfv_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == pcfv_pkg::CFG_GAIN)
            gain_q16 = value;
        else
            min_dist = value[15:0];
    endtask

    // offer one item and queue its expected field at the transfer
    task automatic send_item(input logic [15:0] cx, input logic [15:0] cy, input logic [31:0] q,
                             input logic [15:0] px, input logic [15:0] py, input bit fixed,
                             input field_t res);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px, q, cy, cx};
        do @(posedge clk); while (!s_axis_tready);
        expected_fields.push_back(fixed ? res : coulomb_field(cx, cy, q, px, py));
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // stop offering, then wait for every result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // directed vectors; phase 0 runs with reset registers, phase 1 with max gain, no minimum
    vec_row_t vec_table[] = '{
        '{0, 16'd0, 16'd0, 32'd1000, 16'd0, 16'd0, 1, '{32'd0, 32'd0, 1'b1}},
        '{0, 16'd5, 16'd5, 32'd1000, 16'd19, 16'd5, 1, '{32'd0, 32'd0, 1'b1}},
        '{0, 16'd5, 16'd5, 32'd1000, 16'd20, 16'd5, 0, '0},
        '{0, 16'd0, 16'd0, 32'd1000, 16'd0, 16'hfff2, 1, '{32'd0, 32'd0, 1'b1}},
        '{0, 16'd0, 16'd0, 32'd1000, 16'd0, 16'hfff1, 0, '0},
        '{0, 16'h8000, 16'h8000, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 0, '0},
        '{0, 16'h7fff, 16'h7fff, 32'h8000_0000, 16'h8000, 16'h8000, 0, '0},
        '{0, 16'h8000, 16'h7fff, 32'h7fff_ffff, 16'h7fff, 16'h8000, 0, '0},
        '{0, 16'd0, 16'd0, 32'd0, 16'd100, 16'd100, 1, '{32'd0, 32'd0, 1'b0}},
        '{0, 16'd10, 16'hffe0, 32'hffff_fc18, 16'hffc0, 16'd30, 0, '0},
        '{0, 16'd0, 16'd0, 32'd123456, 16'd16, 16'd0, 0, '0},
        '{0, 16'd0, 16'd0, 32'hffff_ffff, 16'd0, 16'hffe0, 0, '0},
        '{1, 16'd0, 16'd0, 32'd5, 16'd0, 16'd0, 1, '{32'd0, 32'd0, 1'b1}},
        '{1, 16'd0, 16'd0, 32'h7fff_ffff, 16'd1, 16'd0, 1,
          '{pcfv_pkg::SAT_POS, 32'd0, 1'b0}},
        '{1, 16'd0, 16'd0, 32'h8000_0000, 16'd0, 16'd1, 1,
          '{32'd0, pcfv_pkg::SAT_NEG, 1'b0}},
        '{1, 16'd0, 16'd0, 32'h7fff_ffff, 16'hffff, 16'd0, 1,
          '{pcfv_pkg::SAT_NEG, 32'd0, 1'b0}},
        '{1, 16'd0, 16'd0, 32'h8000_0000, 16'd1, 16'hffff, 1,
          '{pcfv_pkg::SAT_NEG, pcfv_pkg::SAT_POS, 1'b0}},
        '{1, 16'h8000, 16'h8000, 32'd1, 16'h7fff, 16'h7fff, 0, '0}
    };

    // random item: mostly near pairs, some full range
    task automatic send_random();
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] q;
        cx = $urandom;
        cy = $urandom;
        q  = $urandom;
        case ($urandom_range(3))
            0: q = $urandom_range(2000);
            1: q = -$urandom_range(2000);
            default: ;
        endcase
        if ($urandom_range(2) == 0)
        begin
            px = $urandom;
            py = $urandom;
        end
        else
        begin
            px = cx + $signed($urandom_range(160)) - 80;
            py = cy + $signed($urandom_range(160)) - 80;
        end
        send_item(cx, cy, q, px, py, 0, '0);
    endtask

    // main sequence
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = pcfv_pkg::CFG_GAIN;
        cfg_data      = '0;
        rx_hold_req   = 1'b0;
        errors        = 0;
        tx_idle_pct   = 26;
        rx_idle_pct   = 69;
        gain_q16      = pcfv_pkg::GAIN_RESET;
        min_dist      = pcfv_pkg::MIN_DIST_RESET;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 7; ph++)
        begin
            // idle pattern per phase
            if (ph >= 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (ph >= 2)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 26;
            end
            case (ph)
                1:
                begin
                    write_reg(pcfv_pkg::CFG_GAIN, 32'hffff_ffff);
                    write_reg(pcfv_pkg::CFG_MIN_DIST, 32'd0);
                end
                2:
                begin
                    write_reg(pcfv_pkg::CFG_GAIN, 32'd0);
                    write_reg(pcfv_pkg::CFG_MIN_DIST, 32'h0000_ffff);
                end
                3:
                begin
                    write_reg(pcfv_pkg::CFG_GAIN, 32'd65536);
                    write_reg(pcfv_pkg::CFG_MIN_DIST, 32'd3);
                end
                4:
                begin
                    write_reg(pcfv_pkg::CFG_GAIN, $urandom);
                    write_reg(pcfv_pkg::CFG_MIN_DIST, $urandom_range(60));
                end
                5:
                begin
                    write_reg(pcfv_pkg::CFG_GAIN, pcfv_pkg::GAIN_RESET);
                    write_reg(pcfv_pkg::CFG_MIN_DIST, 32'd1);
                end
                6:
                begin
                    write_reg(pcfv_pkg::CFG_GAIN, $urandom_range(1 << 20));
                    write_reg(pcfv_pkg::CFG_MIN_DIST, 32'd20);
                end
                default: ;
            endcase
            foreach (vec_table[i])
                if (vec_table[i].phase == ph)
                    send_item(vec_table[i].cx, vec_table[i].cy, vec_table[i].q, vec_table[i].px,
                              vec_table[i].py, vec_table[i].fixed, vec_table[i].res);
            // long receiver hold-off while more items come than the row can hold
            if (ph == 5)
                rx_hold_req = 1'b1;
            for (int n = 0; n < ((ph == 5) ? 250 : 100); n++)
                send_random();
            rx_hold_req = 1'b0;
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && expected_fields.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pcfv_pkg.sv
rtl/pcfv_sqrt_cell.sv
rtl/pcfv_div_cell.sv
rtl/point_charge_field_vector.sv
tb/sv/tb_top.sv
